### hdl/huffman_symbol_encoder_packer_macros.svh
// Assertion macros used by the checker file.
`ifndef HUFFMAN_SYMBOL_ENCODER_PACKER_MACROS_SVH
`define HUFFMAN_SYMBOL_ENCODER_PACKER_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define HSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked around reset.
`define HSE_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int TOTAL_W   = 40;
    localparam int OP_DEPTH  = 4;
    localparam int OP_CNT_W  = $clog2(OP_DEPTH + 1);
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  packed_word;
        logic [LEN_W-1:0]   word_fill;
        logic               is_final;
        logic [TOTAL_W-1:0] total_bits;
    } out_item_t;

    // Work handed from the lookup side to the packer.
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } op_item_t;

endpackage

### hdl/hse_fifo.sv
`timescale 1ns / 1ps

module hse_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output item_t                      head,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t            slots_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = slots_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

### hdl/hse_front.sv
`timescale 1ns / 1ps

module hse_front #(
    parameter int WORD_BITS    = 32,
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  hse_pkg::in_item_t             in_item,
    input  logic [hse_pkg::OP_CNT_W-1:0]  op_count,
    output logic                          op_push,
    output hse_pkg::op_item_t             op_item
);

    localparam int AW        = $clog2(SYMBOL_COUNT);
    localparam int LIM_A     = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_LIMIT = (LIM_A < hse_pkg::CODE_W) ? LIM_A : hse_pkg::CODE_W;
    localparam int ENTRY_W   = hse_pkg::CODE_W + hse_pkg::LEN_W;

    logic [ENTRY_W-1:0]            code_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]       valid_reg;
    logic                          s1_valid_reg;
    logic [1:0]                    s1_cmd_reg;
    logic                          s1_hit_reg;
    logic [hse_pkg::CODE_W-1:0]    rd_code_reg;
    logic [hse_pkg::LEN_W-1:0]     rd_len_reg;

    logic                          accept;
    logic                          in_range;
    logic [AW-1:0]                 idx;
    logic                          load_en;
    logic [hse_pkg::LEN_W-1:0]     sat_len;
    logic [hse_pkg::CODE_W-1:0]    len_mask;

    always_comb
    begin
        full     = ((hse_pkg::OP_CNT_W+1)'(op_count) + (hse_pkg::OP_CNT_W+1)'(s1_valid_reg))
                   >= (hse_pkg::OP_CNT_W+1)'(hse_pkg::OP_DEPTH);
        accept   = push && !full;
        in_range = ({1'b0, in_item.symbol} < 9'(SYMBOL_COUNT));
        idx      = in_item.symbol[AW-1:0];
        load_en  = accept && in_range && (in_item.command == hse_pkg::CMD_LOAD);
        sat_len  = (in_item.code_length > hse_pkg::LEN_W'(LEN_LIMIT))
                   ? hse_pkg::LEN_W'(LEN_LIMIT) : in_item.code_length;
        len_mask = hse_pkg::CODE_W'(((hse_pkg::CODE_W+1)'(1) << sat_len)
                   - (hse_pkg::CODE_W+1)'(1));
    end

    // code table: every accepted request reads it, and a load also writes it
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            code_mem[idx] <= {in_item.code_bits & len_mask, sat_len};
        end
        if (accept)
        begin
            {rd_code_reg, rd_len_reg} <= code_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_cmd_reg   <= hse_pkg::CMD_LOAD;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            if (load_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_cmd_reg <= in_item.command;
                s1_hit_reg <= in_range && valid_reg[idx];
            end
        end
    end

    always_comb
    begin
        op_item.flush       = (s1_cmd_reg == hse_pkg::CMD_FLUSH);
        op_item.code_bits   = rd_code_reg;
        op_item.code_length = rd_len_reg;
        op_push = s1_valid_reg
                  && (((s1_cmd_reg == hse_pkg::CMD_ENCODE) && s1_hit_reg && (rd_len_reg != '0))
                      || (s1_cmd_reg == hse_pkg::CMD_FLUSH));
    end

endmodule

### hdl/hse_back.sv
`timescale 1ns / 1ps

module hse_back #(
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  hse_pkg::op_item_t  op_item,
    output logic               op_pop,
    input  logic               out_ok,
    output logic               res_push,
    output hse_pkg::out_item_t res_item
);

    localparam int FW = $clog2(WORD_BITS + 1);
    localparam int SW = FW + 1;
    localparam int XW = WORD_BITS + hse_pkg::CODE_W;
    localparam int TW = hse_pkg::TOTAL_W;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;
    logic [TW-1:0]        total_reg;
    logic [TW-1:0]        total_next;

    logic [XW-1:0]        wide;
    logic [SW-1:0]        sum;
    logic [TW:0]          tsum;
    logic [TW-1:0]        tsat;

    always_comb
    begin
        wide = {{hse_pkg::CODE_W{1'b0}}, word_reg}
               | ({{WORD_BITS{1'b0}}, op_item.code_bits} << fill_reg);
        sum  = SW'(fill_reg) + SW'(op_item.code_length);
        tsum = {1'b0, total_reg} + (TW+1)'(op_item.code_length);
        tsat = tsum[TW] ? {TW{1'b1}} : tsum[TW-1:0];

        op_pop     = op_valid && out_ok;
        res_push   = 1'b0;
        res_item   = '0;
        word_next  = word_reg;
        fill_next  = fill_reg;
        total_next = total_reg;

        if (op_pop)
        begin
            if (op_item.flush)
            begin
                res_push             = (fill_reg != '0);
                res_item.packed_word = hse_pkg::CODE_W'(word_reg);
                res_item.word_fill   = hse_pkg::LEN_W'(fill_reg);
                res_item.is_final    = 1'b1;
                res_item.total_bits  = total_reg;
                word_next            = '0;
                fill_next            = '0;
                total_next           = '0;
            end
            else
            begin
                total_next = tsat;
                if (sum >= SW'(WORD_BITS))
                begin
                    // word complete; leftover code bits open the next word
                    res_push             = 1'b1;
                    res_item.packed_word = hse_pkg::CODE_W'(wide[WORD_BITS-1:0]);
                    res_item.word_fill   = hse_pkg::LEN_W'(WORD_BITS);
                    res_item.is_final    = 1'b0;
                    res_item.total_bits  = tsat;
                    word_next            = WORD_BITS'(wide >> WORD_BITS);
                    fill_next            = FW'(sum - SW'(WORD_BITS));
                end
                else
                begin
                    word_next = wide[WORD_BITS-1:0];
                    fill_next = FW'(sum);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            word_reg  <= word_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

endmodule

### hdl/huffman_symbol_encoder_packer.sv
`timescale 1ns / 1ps

// Huffman encoder with word packer. Takes one request per cycle while full is
// low (load table entry, encode symbol, flush) and delivers packed words from
// an output queue, one per cycle; a request passes the table read register,
// the lookup-to-packer queue and the output queue. The code table is written
// and read at one index per request, and the packer merges each code with a
// combinational shift. Lookup side and packer are parted by a four-entry queue,
// packer and result port by a two-entry queue. The code table needs no clearing
// pass: one valid bit per entry, cleared by reset, drops unloaded symbols.
module huffman_symbol_encoder_packer #(
    parameter int WORD_BITS    = 32,
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  hse_pkg::in_item_t  symbol_item,
    output logic               empty,
    input  logic               pop,
    output hse_pkg::out_item_t word_item
);

    logic                          op_push;
    hse_pkg::op_item_t             op_in;
    hse_pkg::op_item_t             op_head;
    logic                          op_empty;
    logic [hse_pkg::OP_CNT_W-1:0]  op_count;
    logic                          op_pop;
    logic                          res_push;
    hse_pkg::out_item_t            res_item;
    logic [hse_pkg::OUT_CNT_W-1:0] out_count;
    logic                          out_ok;
    logic                          out_pop;

    hse_front #(
        .WORD_BITS    (WORD_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (symbol_item),
        .op_count (op_count),
        .op_push  (op_push),
        .op_item  (op_in)
    );

    hse_fifo #(
        .item_t (hse_pkg::op_item_t),
        .DEPTH  (hse_pkg::OP_DEPTH)
    ) u_op_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_item (op_in),
        .pop       (op_pop),
        .head      (op_head),
        .empty     (op_empty),
        .count     (op_count)
    );

    assign out_ok = (out_count < hse_pkg::OUT_CNT_W'(hse_pkg::OUT_DEPTH));

    hse_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op_item  (op_head),
        .op_pop   (op_pop),
        .out_ok   (out_ok),
        .res_push (res_push),
        .res_item (res_item)
    );

    assign out_pop = pop && !empty;

    hse_fifo #(
        .item_t (hse_pkg::out_item_t),
        .DEPTH  (hse_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .pop       (out_pop),
        .head      (word_item),
        .empty     (empty),
        .count     (out_count)
    );

endmodule

### hdl/hse_checker.sv
`timescale 1ns / 1ps

`include "huffman_symbol_encoder_packer_macros.svh"

module hse_checker #(
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  logic               pop,
    input  hse_pkg::out_item_t word_item
);

    `HSE_ASSERT_NORST(a_reset_empty, clk, ($rose(rst_n) |-> empty), "result queue not empty after reset")

    `HSE_ASSERT(a_head_holds, clk, rst_n, ((!empty && !pop) |=> (!empty && $stable(word_item))), "waiting result changed")

    `HSE_ASSERT(a_full_word, clk, rst_n, ((!empty && !word_item.is_final) |-> (word_item.word_fill == hse_pkg::LEN_W'(WORD_BITS))), "non-final word not full")

    `HSE_ASSERT(a_final_word, clk, rst_n, ((!empty && word_item.is_final) |-> ((word_item.word_fill != '0) && ((word_item.packed_word >> word_item.word_fill) == '0))), "final word fill or padding wrong")

endmodule

bind huffman_symbol_encoder_packer hse_checker #(
    .WORD_BITS (WORD_BITS)
) u_hse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .word_item (word_item)
);
